// ===== hw/rtl/espc_pkg.sv =====
// shared types and constants for the equal-subset partition checker
package espc_pkg;

  // word of the reachable-sum vector and the split of an element value
  localparam int WORD_BITS = 64;
  localparam int BIT_IDX_W = 6;
  localparam int ELEM_W    = 10;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PRIME,
    ST_SHIFT,
    ST_FLUSH,
    ST_QUERY,
    ST_RESULT
  } state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic clear;
    logic accept;
    logic prime;
    logic shift;
    logic load_result;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic clear_done;
    logic need_shift;
    logic shift_done;
    logic last_in;
    logic last_held;
    logic out_busy;
  } status_t;

endpackage

// ===== hw/rtl/equal_subset_partition_check_top.sv =====
// top level of the equal-subset partition checker
//
// Elements of a set arrive one transaction at a time, the last one marked by
// is_last; the block answers each set with one result transaction giving
// can_partition and sum_overflow. An element that is zero, that pushes the
// set past its limits, or that arrives after the set has overflowed, needs
// no walk; any other element v is folded in by a walk of the reachable-sum
// memory one 64-bit word per cycle from the top word down to word
// floor(v/64), SUM_WORDS = MAX_TOTAL/64 + 1. The last element adds the
// lookup at half the total, the wait for the output register to be free,
// and a clearing pass over all SUM_WORDS words that restores the memory
// for the next set; the same pass runs after reset. No element is accepted
// during the clearing pass.
module equal_subset_partition_check_top #(
  parameter int MAX_TOTAL = 2047,
  parameter int VALUE_MAX = 1023
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [espc_pkg::ELEM_W-1:0] element_value,
  input  logic                        is_last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        can_partition,
  output logic                        sum_overflow
);
  import espc_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer
  espc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  // sum vector, total and result
  espc_dp #(
    .MAX_TOTAL (MAX_TOTAL),
    .VALUE_MAX (VALUE_MAX)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .element_value (element_value),
    .is_last       (is_last),
    .out_ready     (out_ready),
    .cmd           (cmd),
    .status        (status),
    .can_partition (can_partition),
    .sum_overflow  (sum_overflow),
    .out_valid     (out_valid)
  );

endmodule

// ===== hw/rtl/espc_ctrl.sv =====
// controller state machine for the equal-subset partition checker
module espc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output espc_pkg::cmd_t    cmd,
  input  espc_pkg::status_t status
);
  import espc_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (status.need_shift) begin
            state_next = ST_PRIME;
          end else if (status.last_in) begin
            state_next = ST_QUERY;
          end
        end
      end
      ST_PRIME: begin
        cmd.prime  = 1'b1;
        state_next = ST_SHIFT;
      end
      ST_SHIFT: begin
        cmd.shift = 1'b1;
        if (status.shift_done) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_next = status.last_held ? ST_QUERY : ST_IDLE;
      end
      ST_QUERY: begin
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (!status.out_busy) begin
          cmd.load_result = 1'b1;
          state_next      = ST_CLEAR;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== hw/rtl/espc_dp.sv =====
// datapath of the equal-subset partition checker: sum-vector memory, total, result
module espc_dp #(
  parameter int MAX_TOTAL = 2047,
  parameter int VALUE_MAX = 1023
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [espc_pkg::ELEM_W-1:0]  element_value,
  input  logic                         is_last,
  input  logic                         out_ready,
  input  espc_pkg::cmd_t               cmd,
  output espc_pkg::status_t            status,
  output logic                         can_partition,
  output logic                         sum_overflow,
  output logic                         out_valid
);
  import espc_pkg::*;

  localparam int SUM_WORDS = MAX_TOTAL / WORD_BITS + 1;
  localparam int AW        = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;
  localparam int TW        = $clog2(MAX_TOTAL + 1);
  localparam int SW        = ((TW > ELEM_W) ? TW : ELEM_W) + 1;
  localparam int VCMP_W    = 17;
  localparam logic [AW-1:0] TOP = AW'(SUM_WORDS - 1);

  logic [WORD_BITS-1:0] mem [SUM_WORDS];

  logic [AW-1:0]        idx;
  logic [AW-1:0]        ws;
  logic [BIT_IDX_W-1:0] bs;
  logic                 last_q;
  logic [TW-1:0]        total;
  logic                 overflowed;
  logic [AW-1:0]        src;
  logic [AW-1:0]        addr_a;
  logic [AW-1:0]        addr_b;
  logic [WORD_BITS-1:0] rd_a;
  logic [WORD_BITS-1:0] rd_b;
  logic [WORD_BITS-1:0] b_prev;
  logic                 b_zero;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_lo;
  logic [WORD_BITS-1:0] wr_data;
  logic [SW-1:0]        sum_in;
  logic                 over_in;
  logic [TW-1:0]        half;
  logic [AW-1:0]        qword;
  logic [BIT_IDX_W-1:0] qbit;

  // total check for the incoming transaction
  assign sum_in  = SW'(total) + SW'(element_value);
  assign over_in = (VCMP_W'(element_value) > VCMP_W'(VALUE_MAX)) ||
                   (sum_in > SW'(MAX_TOTAL));

  // source word of the shift for the current destination word
  assign src = idx - ws;

  // query position at half the total
  assign half  = total >> 1;
  assign qword = AW'(half >> BIT_IDX_W);
  assign qbit  = half[BIT_IDX_W-1:0];

  // read addresses: destination and next lower source word while shifting
  assign addr_a = cmd.shift ? idx : qword;
  assign addr_b = cmd.prime ? src : (src - AW'(1));

  // merged word: old value, current source shifted up, carry from the word below
  assign wr_lo   = (bs == '0 || b_zero) ? '0 :
                   (rd_b >> (7'(WORD_BITS) - 7'(bs)));
  assign wr_data = rd_a | (b_prev << bs) | wr_lo;

  // sum-vector memory, one write and two registered reads
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[idx] <= (idx == '0) ? WORD_BITS'(1) : '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a   <= mem[addr_a];
    rd_b   <= mem[addr_b];
    b_prev <= rd_b;
  end

  // control registers: word counter, total, overflow, write strobe, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      total      <= '0;
      overflowed <= 1'b0;
      wr_en      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      wr_en <= cmd.shift;
      if (cmd.clear) begin
        idx <= idx + AW'(1);
      end else if (cmd.accept) begin
        idx <= TOP;
      end else if (cmd.shift) begin
        idx <= idx - AW'(1);
      end else if (cmd.load_result) begin
        idx <= '0;
      end
      if (cmd.clear) begin
        total      <= '0;
        overflowed <= 1'b0;
      end else if (cmd.accept && !overflowed) begin
        if (over_in) begin
          overflowed <= 1'b1;
        end else begin
          total <= TW'(sum_in);
        end
      end
      if (cmd.load_result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers of the transaction in work and of the result
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ws     <= AW'(element_value >> BIT_IDX_W);
      bs     <= element_value[BIT_IDX_W-1:0];
      last_q <= is_last;
    end
    if (cmd.shift) begin
      wr_addr <= idx;
      b_zero  <= (src == '0);
    end
    if (cmd.load_result) begin
      can_partition <= !overflowed && !total[0] && rd_a[qbit];
      sum_overflow  <= overflowed;
    end
  end

  // status towards the controller
  always_comb begin
    status.clear_done = cmd.clear && (idx == TOP);
    status.need_shift = !overflowed && !over_in && (element_value != '0);
    status.shift_done = (idx == ws);
    status.last_in    = is_last;
    status.last_held  = last_q;
    status.out_busy   = out_valid && !out_ready;
  end

  // the total never passes the limit
  assert property (@(posedge clk) disable iff (rst) 32'(total) <= MAX_TOTAL)
    else $error("running total above limit");

  // a shifted word is never written below the word shift
  assert property (@(posedge clk) disable iff (rst) wr_en |-> (wr_addr >= ws))
    else $error("shift write below word offset");

  // once overflowed the total stays frozen until the set is cleared
  assert property (@(posedge clk) disable iff (rst)
                   (overflowed && !cmd.clear) |=> $stable(total))
    else $error("total changed after overflow");

  // a result is loaded only into a free output register
  assert property (@(posedge clk) disable iff (rst)
                   cmd.load_result |-> !status.out_busy)
    else $error("result loaded over a pending transaction");

endmodule

// ===== tb/espc_checker.sv =====
// checker for the equal-subset partition block: predicts each set's verdict and compares
`timescale 1ns / 100ps

module espc_checker #(
  parameter int MAX_TOTAL = 2047,
  parameter int VALUE_MAX = 1023
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [espc_pkg::ELEM_W-1:0] element_value,
  input  logic                        is_last,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic                        can_partition,
  input  logic                        sum_overflow,
  output int                          mismatches,
  output int                          outstanding,
  output int                          sets_done,
  output int                          sets_split,
  output int                          sets_overflowed
);

  // sum vector spans whole words, covering totals 0..MAX_TOTAL
  localparam int SUM_BITS = (MAX_TOTAL / espc_pkg::WORD_BITS + 1) * espc_pkg::WORD_BITS;

  typedef struct packed {
    logic can_partition;
    logic sum_overflow;
  } verdict_t;

  logic [SUM_BITS-1:0] reach_vec;
  int unsigned         set_total;
  logic                set_overflowed;
  verdict_t            verdict_q[$];
  int                  err_count   = 0;
  int                  done_count  = 0;
  int                  split_count = 0;
  int                  ovf_count   = 0;

  // one line per mismatch, counted
  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    err_count++;
  endtask

  // back to an empty set: only sum zero reachable
  task automatic restart_set();
    reach_vec      = '0;
    reach_vec[0]   = 1'b1;
    set_total      = 0;
    set_overflowed = 1'b0;
  endtask

  // fold one element into the set; the last one yields a verdict
  task automatic absorb_element(input logic [espc_pkg::ELEM_W-1:0] v, input logic last);
    verdict_t    verdict;
    int unsigned half;
    if (!set_overflowed) begin
      if (v > VALUE_MAX || set_total + v > MAX_TOTAL) begin
        set_overflowed = 1'b1;
      end else begin
        set_total += v;
        reach_vec = reach_vec | (reach_vec << v);
      end
    end
    if (last) begin
      half = set_total / 2;
      verdict.can_partition = !set_overflowed && (set_total % 2 == 0) && reach_vec[half];
      verdict.sum_overflow  = set_overflowed;
      verdict_q.push_back(verdict);
      restart_set();
    end
  endtask

  // compare a result transaction with the oldest pending verdict
  task automatic check_result();
    verdict_t want;
    if (verdict_q.size() == 0) begin
      report_mismatch($sformatf("result (%b,%b) with no set pending",
                                can_partition, sum_overflow));
      return;
    end
    want = verdict_q.pop_front();
    done_count++;
    if (want.can_partition) split_count++;
    if (want.sum_overflow) ovf_count++;
    if (can_partition !== want.can_partition)
      report_mismatch($sformatf("set %0d can_partition got %b expected %b",
                                done_count, can_partition, want.can_partition));
    if (sum_overflow !== want.sum_overflow)
      report_mismatch($sformatf("set %0d sum_overflow got %b expected %b",
                                done_count, sum_overflow, want.sum_overflow));
  endtask

  // results are checked before the same edge's element is folded in
  always @(posedge clk) begin
    if (rst) begin
      restart_set();
      verdict_q.delete();
    end else begin
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) absorb_element(element_value, is_last);
    end
    outstanding     <= verdict_q.size();
    mismatches      <= err_count;
    sets_done       <= done_count;
    sets_split      <= split_count;
    sets_overflowed <= ovf_count;
  end

endmodule

// ===== tb/tb.sv =====
// testbench top for the equal-subset partition checker: stimulus and verdict
`timescale 1ns / 100ps

module tb;

  localparam int MAX_TOTAL       = 2047;
  localparam int VALUE_MAX       = 1023;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int ELEM_W          = espc_pkg::ELEM_W;

  logic              clk           = 1'b0;
  logic              rst           = 1'b1;
  logic              in_valid      = 1'b0;
  logic [ELEM_W-1:0] element_value = '0;
  logic              is_last       = 1'b0;
  logic              out_ready     = 1'b0;
  logic              in_ready;
  logic              out_valid;
  logic              can_partition;
  logic              sum_overflow;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent    = 0;
  int mismatches;
  int outstanding;
  int sets_done;
  int sets_split;
  int sets_overflowed;

  equal_subset_partition_check_top #(
    .MAX_TOTAL(MAX_TOTAL),
    .VALUE_MAX(VALUE_MAX)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .element_value(element_value),
    .is_last      (is_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .can_partition(can_partition),
    .sum_overflow (sum_overflow)
  );

  espc_checker #(
    .MAX_TOTAL(MAX_TOTAL),
    .VALUE_MAX(VALUE_MAX)
  ) partition_chk (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .element_value  (element_value),
    .is_last        (is_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .can_partition  (can_partition),
    .sum_overflow   (sum_overflow),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .sets_done      (sets_done),
    .sets_split     (sets_split),
    .sets_overflowed(sets_overflowed)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver stalls at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // one element transaction, with a random gap ahead of it
  task automatic send_element(input logic [ELEM_W-1:0] v, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    element_value <= v;
    is_last       <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // hold off the sender until every pending set has been answered
  task automatic drain_verdicts();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // a whole set with random content, shaped by one of several mixes
  task automatic send_random_set();
    logic [ELEM_W-1:0] vals[$];
    logic [ELEM_W-1:0] tmp;
    int                mix;
    int                len;
    int                cap;
    int                j;
    int                k;
    mix = $urandom_range(0, 9);
    if (mix < 3) begin
      // small values, even splits are common
      len = $urandom_range(1, 8);
      repeat (len) vals.push_back(ELEM_W'($urandom_range(0, 31)));
    end else if (mix < 6) begin
      // mirrored pairs in shuffled order, always splittable
      len = $urandom_range(1, 5);
      cap = MAX_TOTAL / (2 * len);
      if (cap > VALUE_MAX) cap = VALUE_MAX;
      repeat (len) begin
        tmp = ELEM_W'($urandom_range(0, cap));
        vals.push_back(tmp);
        vals.push_back(tmp);
      end
      for (j = vals.size() - 1; j > 0; j--) begin
        k       = $urandom_range(0, j);
        tmp     = vals[j];
        vals[j] = vals[k];
        vals[k] = tmp;
      end
    end else if (mix < 8) begin
      // full-range values, at times running past the sum limit
      len = $urandom_range(1, 6);
      repeat (len) vals.push_back(ELEM_W'($urandom_range(0, 1023)));
    end else begin
      // medium values, shifts across word boundaries
      len = $urandom_range(2, 10);
      repeat (len) vals.push_back(ELEM_W'($urandom_range(0, 255)));
    end
    foreach (vals[i]) send_element(vals[i], i == vals.size() - 1);
  endtask

  // stimulus and verdict
  initial begin
    logic [ELEM_W:0] directed[$];
    // {last, value}: zero set, odd total, two maxima, exact limit,
    // overflow then frozen element, zeros, small split, word-aligned shift,
    // shift across a word boundary, alternating bit patterns
    directed = '{
      {1'b1, 10'd0},
      {1'b1, 10'd1023},
      {1'b0, 10'd1023}, {1'b1, 10'd1023},
      {1'b0, 10'd1023}, {1'b0, 10'd1023}, {1'b1, 10'd1},
      {1'b0, 10'd1023}, {1'b0, 10'd1023}, {1'b0, 10'd2}, {1'b1, 10'd5},
      {1'b0, 10'd0}, {1'b0, 10'd0}, {1'b1, 10'd0},
      {1'b0, 10'd3}, {1'b0, 10'd1}, {1'b0, 10'd1}, {1'b1, 10'd1},
      {1'b0, 10'd64}, {1'b1, 10'd64},
      {1'b0, 10'd63}, {1'b0, 10'd1}, {1'b1, 10'd64},
      {1'b0, 10'd682}, {1'b1, 10'd341}
    };
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // sender mostly busy, receiver mostly stalling
    send_idle_pct = 16;
    recv_idle_pct = 73;
    foreach (directed[i]) send_element(directed[i][ELEM_W-1:0], directed[i][ELEM_W]);
    drain_verdicts();
    while (items_sent < ITEMS_PER_PHASE) send_random_set();
    drain_verdicts();

    // sender mostly idle, receiver mostly ready
    send_idle_pct = 73;
    recv_idle_pct = 16;
    while (items_sent < 2 * ITEMS_PER_PHASE) send_random_set();
    drain_verdicts();

    // back to back on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (items_sent < 3 * ITEMS_PER_PHASE) send_random_set();
    drain_verdicts();

    // room for the clearing pass and any stray result
    repeat (80) @(posedge clk);
    $display("%0d elements in %0d sets over three idling mixes: %0d split evenly, %0d overflowed",
             items_sent, sets_done, sets_split, sets_overflowed);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("timeout with %0d sets still pending", outstanding);
    $display("TB_ERROR");
    $finish;
  end

endmodule
